[design/load_sampling_gate_with_hysteresis_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the load sampling gate
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LOAD_SAMPLING_GATE_WITH_HYSTERESIS_DEFINES_SVH
`define LOAD_SAMPLING_GATE_WITH_HYSTERESIS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("load sampling gate: check failed");
// next-cycle implication
`define LSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("load sampling gate: check failed");
`else
`define LSG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/lsg_pkg.sv]
// ----------------------------------------------------------------------------
// lsg_pkg
// Shared widths, register indexes and level codes of the load sampling gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsg_pkg;

  localparam int LOAD_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONITOR_LEVEL       = 3'd0,
    REG_SAMPLE_INTERVAL     = 3'd1,
    REG_DYNAMIC_ENABLE      = 3'd2,
    REG_HIGH_LOAD_THRESHOLD = 3'd3,
    REG_RELEASE_HYSTERESIS  = 3'd4,
    REG_BASIC_THRESHOLD     = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_BASIC  = 2'd1,
    LVL_SAMPLE = 2'd2,
    LVL_FULL   = 2'd3
  } level_t;

  localparam level_t           RST_LEVEL     = LVL_SAMPLE;
  localparam logic [LOAD_W-1:0] RST_INTERVAL  = 16'd10;
  localparam logic              RST_DYNAMIC   = 1'b1;
  localparam logic [LOAD_W-1:0] RST_HIGH_THR  = 16'd8000;
  localparam logic [LOAD_W-1:0] RST_HYST      = 16'd1000;
  localparam logic [LOAD_W-1:0] RST_BASIC_THR = 16'd10000;

endpackage

[design/load_sampling_gate_with_hysteresis.sv]
// ----------------------------------------------------------------------------
// load_sampling_gate_with_hysteresis
// Decides per load sample whether it goes to the full logger.
// ----------------------------------------------------------------------------
// One load sample word is taken at a time. The hysteresis flag and the
// forward decision are settled in the cycle the word is accepted; the
// running average then goes through a shift-and-add multiplier, which
// stops after the highest set bit of the average count, and a restoring
// divider (one quotient bit each cycle). With monitoring off the average
// is skipped and the word goes straight to the output. The result sits
// in an output register, so the next sample may be accepted while that
// word still waits to be taken. Writing the level clears the sample
// counter unless a word is accepted in the same cycle; an interval of
// zero is stored as one.
`timescale 1ns / 1ps
`include "load_sampling_gate_with_hysteresis_defines.svh"

module load_sampling_gate_with_hysteresis
  import lsg_pkg::*;
#(
  parameter int AVERAGE_WINDOW = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // sample words in
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LOAD_W-1:0]    load_sample,
  // result words out
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 forward_sample,
  output logic [LOAD_W-1:0]    forwarded_load,
  output logic                 high_load_active,
  output logic [LOAD_W-1:0]    load_average
);

  // count holds 0..window, divisor 1..window+1
  localparam int CNT_W = $clog2(AVERAGE_WINDOW + 1);
  localparam int DIV_W = $clog2(AVERAGE_WINDOW + 2);
  localparam int SUM_W = LOAD_W + DIV_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

  state_t state;

  // configuration registers
  level_t            monitor_level;
  logic [LOAD_W-1:0] sample_interval;
  logic              dynamic_enable;
  logic [LOAD_W-1:0] high_load_threshold;
  logic [LOAD_W-1:0] release_hysteresis;
  logic [LOAD_W-1:0] basic_threshold;

  // block state
  logic              high_load_flag;
  logic [LOAD_W-1:0] sample_counter;
  logic [LOAD_W-1:0] average_value;
  logic [CNT_W-1:0]  average_count;

  // per-word result held while the average is worked out
  logic              res_fwd;
  logic [LOAD_W-1:0] res_load;

  logic              accept;
  logic              out_free;
  logic              mul_start;
  logic              mul_done;
  logic [SUM_W-1:0]  mul_product;
  logic              div_done;
  logic [LOAD_W-1:0] div_quotient;
  logic [SUM_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [CNT_W-1:0]  average_count_next;

  logic              release_ok;
  logic              flag_next;
  logic              fwd_next;
  logic [LOAD_W-1:0] counter_inc;
  logic [LOAD_W-1:0] sample_counter_next;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mul_start = accept && (monitor_level != LVL_OFF);

  // release test done wide so the sum cannot wrap
  assign release_ok = ({1'b0, load_sample} + {1'b0, release_hysteresis})
                      < {1'b0, high_load_threshold};
  assign counter_inc = sample_counter + LOAD_W'(1);

  always_comb begin
    flag_next           = high_load_flag;
    fwd_next            = 1'b0;
    sample_counter_next = sample_counter;
    if (monitor_level != LVL_OFF) begin
      if (dynamic_enable) begin
        flag_next = high_load_flag ? !release_ok : (load_sample > high_load_threshold);
      end
      priority if (dynamic_enable && flag_next) begin
        // high-load forward leaves the sample counter alone
        fwd_next = 1'b1;
      end else if (monitor_level == LVL_BASIC) begin
        fwd_next = (load_sample > basic_threshold);
      end else if (monitor_level == LVL_SAMPLE) begin
        if (counter_inc >= sample_interval) begin
          fwd_next            = 1'b1;
          sample_counter_next = '0;
        end else begin
          sample_counter_next = counter_inc;
        end
      end else begin
        fwd_next = 1'b1;
      end
    end
  end

  // (average * count + load) / (count + 1), count capped at the window
  assign div_dividend       = mul_product + SUM_W'(res_load);
  assign div_divisor        = DIV_W'(average_count) + DIV_W'(1);
  assign average_count_next = (average_count == CNT_W'(AVERAGE_WINDOW)) ?
                              average_count : average_count + CNT_W'(1);

  lsg_serial_mul #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .start       (mul_start),
    .multiplicand(average_value),
    .multiplier  (average_count),
    .done        (mul_done),
    .product     (mul_product)
  );

  lsg_serial_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_done),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // configuration writes; unknown indexes drop out through the default arm
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_level       <= RST_LEVEL;
      sample_interval     <= RST_INTERVAL;
      dynamic_enable      <= RST_DYNAMIC;
      high_load_threshold <= RST_HIGH_THR;
      release_hysteresis  <= RST_HYST;
      basic_threshold     <= RST_BASIC_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MONITOR_LEVEL:       monitor_level <= level_t'(cfg_data[1:0]);
        REG_SAMPLE_INTERVAL:     sample_interval <= (cfg_data == '0) ?
                                                    LOAD_W'(1) : cfg_data;
        REG_DYNAMIC_ENABLE:      dynamic_enable <= cfg_data[0];
        REG_HIGH_LOAD_THRESHOLD: high_load_threshold <= cfg_data;
        REG_RELEASE_HYSTERESIS:  release_hysteresis <= cfg_data;
        REG_BASIC_THRESHOLD:     basic_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      high_load_flag <= 1'b0;
      sample_counter <= '0;
      average_value  <= '0;
      average_count  <= '0;
    end else begin
      // drop a word once it has been taken, unless the next one replaces it
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      // a level write restarts the sampling count, unless a word is accepted
      if (cfg_we && (cfg_index == REG_MONITOR_LEVEL) && !accept) begin
        sample_counter <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            high_load_flag <= flag_next;
            sample_counter <= sample_counter_next;
            res_fwd        <= fwd_next;
            res_load       <= load_sample;
            state          <= (monitor_level == LVL_OFF) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            average_value <= div_quotient;
            average_count <= average_count_next;
            state         <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand the word over as soon as the output register is free
          if (out_free) begin
            out_valid        <= 1'b1;
            forward_sample   <= res_fwd;
            forwarded_load   <= res_fwd ? res_load : '0;
            high_load_active <= high_load_flag;
            load_average     <= average_value;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LSG_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)
  `LSG_ASSERT_IMPL(a_dropped_is_zero, clk, rst, out_valid && !forward_sample, forwarded_load == '0)
  `LSG_ASSERT_IMPL(a_count_capped, clk, rst, 1'b1, average_count <= CNT_W'(AVERAGE_WINDOW))
  `LSG_ASSERT_IMPL(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)

endmodule

[design/lsg_serial_mul.sv]
// ----------------------------------------------------------------------------
// lsg_serial_mul
// Shift-and-add multiplier: one multiplier bit per cycle, stops early.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsg_serial_mul
  import lsg_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int SUM_W = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LOAD_W-1:0] multiplicand,
  input  logic [CNT_W-1:0]  multiplier,
  output logic              done,
  output logic [SUM_W-1:0]  product
);

  logic             busy;
  logic [SUM_W-1:0] mcand;
  logic [CNT_W-1:0] mplier;
  logic [SUM_W-1:0] acc;

  assign done    = busy && (mplier == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      mcand  <= SUM_W'(multiplicand);
      mplier <= multiplier;
      acc    <= '0;
    end else if (busy) begin
      if (mplier != '0) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[SUM_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[CNT_W-1:1]};
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[design/lsg_serial_div.sv]
// ----------------------------------------------------------------------------
// lsg_serial_div
// Restoring divider: one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsg_serial_div
  import lsg_pkg::*;
#(
  parameter int DIV_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [LOAD_W+DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic [LOAD_W-1:0]       quotient
);

  localparam int STEP_W = $clog2(LOAD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvsr;
  logic [LOAD_W-1:0] shreg;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    diff;
  logic              fits;

  // the upper bits of the dividend are already below the divisor
  assign rem_sh = {rem, shreg[LOAD_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr};
  assign fits   = ~diff[DIV_W];

  assign done     = busy && (steps == '0);
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(LOAD_W);
      rem   <= dividend[LOAD_W+DIV_W-1:LOAD_W];
      shreg <= dividend[LOAD_W-1:0];
      dvsr  <= divisor;
    end else if (busy) begin
      if (steps != '0) begin
        rem   <= fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        shreg <= {shreg[LOAD_W-2:0], fits};
        steps <= steps - STEP_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load sampling gate testbench
// Feeds load sample words through the gate under a series of register
// settings, predicts every result word (forward decision, echoed load,
// high-load flag and running average) and compares each field as it is
// taken. Both sides idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import lsg_pkg::*;

  localparam int AVG_WINDOW       = 100;
  localparam int LONG_HOLD_AT     = 200;  // result word after which the receiver holds off
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 10;
  localparam int WORDS_PER_PHASE  = 72;
  localparam int SETTLE_CYCLES    = 40;   // longer than the slowest sample

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              fwd;
    logic [LOAD_W-1:0] fload;
    logic              flag;
    logic [LOAD_W-1:0] avg;
  } gate_word_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_MONITOR_LEVEL;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [LOAD_W-1:0]    load_sample = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic                 forward_sample;
  logic [LOAD_W-1:0]    forwarded_load;
  logic                 high_load_active;
  logic [LOAD_W-1:0]    load_average;

  always #5 clk = ~clk;

  load_sampling_gate_with_hysteresis #(
    .AVERAGE_WINDOW(AVG_WINDOW)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .load_sample      (load_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .forward_sample   (forward_sample),
    .forwarded_load   (forwarded_load),
    .high_load_active (high_load_active),
    .load_average     (load_average)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the gate's state
  // --------------------------------------------------------------------------
  level_t            cur_level   = RST_LEVEL;
  logic [LOAD_W-1:0] interval    = RST_INTERVAL;
  logic              dyn_enable  = RST_DYNAMIC;
  logic [LOAD_W-1:0] high_thr    = RST_HIGH_THR;
  logic [LOAD_W-1:0] hyst        = RST_HYST;
  logic [LOAD_W-1:0] basic_thr   = RST_BASIC_THR;

  logic              high_flag    = 1'b0;
  logic [LOAD_W-1:0] sample_count = '0;
  logic [LOAD_W-1:0] avg_value    = '0;
  logic [6:0]        avg_count    = '0;

  logic [LOAD_W-1:0] load_queue[$];      // words waiting to be offered
  gate_word_t        expected_words[$];  // predicted result words, oldest first

  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int tx_wait    = 0;
  int rx_wait    = 0;
  int rx_taken   = 0;

  int mismatch_count = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int forwarded      = 0;
  int high_entries   = 0;
  int settings_used  = 0;
  bit [3:0] levels_seen = '0;

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Advance the predicted gate by one sample word and return its result word.
  function automatic gate_word_t predict_gate(input logic [LOAD_W-1:0] load);
    gate_word_t  w;
    logic [31:0] total;
    w = '0;
    if (cur_level != LVL_OFF) begin
      // capped cumulative average, truncating divide
      total     = 32'(avg_value) * 32'(avg_count) + 32'(load);
      avg_value = 16'(total / (32'(avg_count) + 32'd1));
      if (avg_count < AVG_WINDOW)
        avg_count++;

      // hysteresis: release sum taken one bit wider so it cannot wrap
      if (dyn_enable) begin
        if (!high_flag && load > high_thr) begin
          high_flag = 1'b1;
          high_entries++;
        end else if (high_flag && (17'(load) + 17'(hyst)) < 17'(high_thr)) begin
          high_flag = 1'b0;
        end
      end

      // high load forwards without touching the sample counter
      if (dyn_enable && high_flag) begin
        w.fwd = 1'b1;
      end else begin
        case (cur_level)
          LVL_BASIC: begin
            w.fwd = (load > basic_thr);
          end
          LVL_SAMPLE: begin
            sample_count++;
            if (sample_count >= interval) begin
              w.fwd        = 1'b1;
              sample_count = '0;
            end
          end
          default: begin
            w.fwd = 1'b1;
          end
        endcase
      end
    end
    w.fload = w.fwd ? load : '0;
    w.flag  = high_flag;
    w.avg   = avg_value;
    return w;
  endfunction

  // Write one register and mirror it in the predictor; only called while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MONITOR_LEVEL: begin
        cur_level    = level_t'(value[1:0]);
        sample_count = '0;
        levels_seen[value[1:0]] = 1'b1;
      end
      REG_SAMPLE_INTERVAL:     interval   = (value == '0) ? 16'd1 : value;
      REG_DYNAMIC_ENABLE:      dyn_enable = value[0];
      REG_HIGH_LOAD_THRESHOLD: high_thr   = value;
      REG_RELEASE_HYSTERESIS:  hyst       = value;
      REG_BASIC_THRESHOLD:     basic_thr  = value;
      default: ;
    endcase
  endtask

  // Block until every word has been offered, accepted and its result taken.
  task automatic wait_drained();
    do @(negedge clk);
    while (load_queue.size() != 0 || in_valid || expected_words.size() != 0);
  endtask

  // Pick a load: mostly near the thresholds in force, so the flag both
  // enters and leaves high load, with extremes and full-range noise mixed in.
  function automatic logic [LOAD_W-1:0] pick_load();
    int v;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2, 3, 4: v = int'(high_thr) + int'($urandom_range(0, 6)) - 3;
      5, 6, 7: v = int'(high_thr) - int'(hyst) + int'($urandom_range(0, 6)) - 3;
      8:       v = int'(basic_thr) + int'($urandom_range(0, 2)) - 1;
      default: return 16'($urandom);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Choose a register setting: the high extremes, the low extremes, or random.
  task automatic shuffle_settings(input int mode);
    level_t lvl;
    settings_used++;
    if (mode == 0) begin
      write_reg(REG_MONITOR_LEVEL,       {14'($urandom), LVL_SAMPLE});
      write_reg(REG_SAMPLE_INTERVAL,     16'hFFFF);
      write_reg(REG_DYNAMIC_ENABLE,      {15'($urandom), 1'b1});
      write_reg(REG_HIGH_LOAD_THRESHOLD, 16'hFFFF);
      write_reg(REG_RELEASE_HYSTERESIS,  16'hFFFF);
      write_reg(REG_BASIC_THRESHOLD,     16'hFFFF);
    end else if (mode == 1) begin
      write_reg(REG_MONITOR_LEVEL,       {14'($urandom), LVL_BASIC});
      write_reg(REG_SAMPLE_INTERVAL,     16'h0000);
      write_reg(REG_DYNAMIC_ENABLE,      {15'($urandom), 1'b1});
      write_reg(REG_HIGH_LOAD_THRESHOLD, 16'h0000);
      write_reg(REG_RELEASE_HYSTERESIS,  16'h0000);
      write_reg(REG_BASIC_THRESHOLD,     16'h0000);
    end else begin
      case ($urandom_range(0, 2))
        0:       write_reg(REG_SAMPLE_INTERVAL, 16'($urandom_range(0, 1)));
        1:       write_reg(REG_SAMPLE_INTERVAL, 16'($urandom_range(2, 16)));
        default: write_reg(REG_SAMPLE_INTERVAL, 16'($urandom_range(2, 6)));
      endcase
      write_reg(REG_DYNAMIC_ENABLE, {15'($urandom), 1'($urandom_range(0, 1))});
      write_reg(REG_HIGH_LOAD_THRESHOLD, 16'($urandom_range(500, 65000)));
      write_reg(REG_RELEASE_HYSTERESIS,
                ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)));
      write_reg(REG_BASIC_THRESHOLD, 16'($urandom));
      // leave the level (and so the sample counter) alone now and then
      if ($urandom_range(0, 3) != 0) begin
        lvl = ($urandom_range(0, 7) == 0) ? LVL_OFF : level_t'($urandom_range(1, 3));
        write_reg(REG_MONITOR_LEVEL, {14'($urandom), lvl});
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer words from load_queue, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      load_sample <= '0;
      tx_wait      = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_words.push_back(predict_gate(load_sample));
        words_sent++;
      end
      // hold off, offer the next word, or drop valid when nothing is pending
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (load_queue.size() != 0) begin
        load_sample <= load_queue.pop_front();
        in_valid    <= 1'b1;
        tx_wait      = $urandom_range(0, tx_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall for a drawn number of cycles after each word taken, and
  // once for a long stretch so that the gate fills and stalls its input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait    = 0;
      rx_taken   = 0;
    end else if (out_valid && !out_stall) begin
      rx_taken++;
      if (rx_taken == LONG_HOLD_AT)
        rx_wait = LONG_HOLD_CYCLES;
      else
        rx_wait = $urandom_range(0, rx_gap_max);
      if (rx_wait > 0)
        out_stall <= 1'b1;
    end else if (out_stall) begin
      rx_wait--;
      if (rx_wait == 0)
        out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result word taken with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    gate_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word taken with no prediction waiting");
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (want.fwd)
          forwarded++;
        if (forward_sample !== want.fwd)
          report_mismatch($sformatf("word %0d forward_sample %b, want %b",
                                    words_checked, forward_sample, want.fwd));
        if (forwarded_load !== want.fload)
          report_mismatch($sformatf("word %0d forwarded_load %0d, want %0d",
                                    words_checked, forwarded_load, want.fload));
        if (high_load_active !== want.flag)
          report_mismatch($sformatf("word %0d high_load_active %b, want %b",
                                    words_checked, high_load_active, want.flag));
        if (load_average !== want.avg)
          report_mismatch($sformatf("word %0d load_average %0d, want %0d",
                                    words_checked, load_average, want.avg));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed checks first, then random phases under new settings
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    levels_seen[RST_LEVEL] = 1'b1;

    // Reset settings: enter high load at full scale, hold at exactly the
    // release edge, drop just below it, then count out one interval.
    @(negedge clk);
    load_queue = '{16'd0, 16'hFFFF, 16'd7000, 16'd6999,
                   16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000,
                   16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000};
    wait_drained();

    // Undecoded indexes must change nothing; level off freezes all state.
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    write_reg(REG_MONITOR_LEVEL, {14'($urandom), LVL_OFF});
    @(negedge clk);
    load_queue = '{16'hFFFF, 16'h5555, 16'hAAAA};
    wait_drained();

    // Basic level without the override: strictly above the threshold only.
    write_reg(REG_DYNAMIC_ENABLE, 16'hFFFE);
    write_reg(REG_MONITOR_LEVEL, {14'($urandom), LVL_BASIC});
    @(negedge clk);
    load_queue = '{16'd10000, 16'd10001, 16'hFFFF};
    wait_drained();

    // Full level forwards everything; a zero interval behaves as one.
    write_reg(REG_MONITOR_LEVEL, {14'($urandom), LVL_FULL});
    @(negedge clk);
    load_queue = '{16'd0};
    wait_drained();
    write_reg(REG_SAMPLE_INTERVAL, 16'h0000);
    write_reg(REG_MONITOR_LEVEL, {14'($urandom), LVL_SAMPLE});
    @(negedge clk);
    load_queue = '{16'd1, 16'd2};
    wait_drained();

    // Random phases; some run with no idling at all on one side or both.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      shuffle_settings(p);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      @(negedge clk);
      repeat (WORDS_PER_PHASE)
        load_queue.push_back(pick_load());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never taken", expected_words.size()));

    $display("Ran %0d sample words under %0d random settings, levels seen mask %b.",
             words_sent, settings_used, levels_seen);
    $display("Checked %0d result words: %0d forwarded, %0d high-load entries, %0d mismatches.",
             words_checked, forwarded, high_entries, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up well past the slowest correct run.
  initial begin
    #4_000_000;
    $display("Timed out with %0d words pending and %0d predictions waiting.",
             load_queue.size(), expected_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
